// File: rtl/tpsv_pkg.sv
// ----------------------------------------------------------------------------
// tpsv_pkg
// Shared sizes, codes and types for the trilinear point splat voxelizer.
// ----------------------------------------------------------------------------
package tpsv_pkg;

   // grid extent
   localparam int MAX_X      = 32;
   localparam int MAX_Y      = 32;
   localparam int MAX_Z      = 32;
   localparam int GRID_CELLS = MAX_X * MAX_Y * MAX_Z;
   localparam int GRID_AW    = $clog2(GRID_CELLS);

   // field widths
   localparam int DIM_W      = 6;
   localparam int REQ_TYPE_W = 2;
   localparam int POS_W      = 16;
   localparam int VIDX_W     = 15;
   localparam int GRAD_W     = 18;
   localparam int CNT_W      = 4;
   localparam int OCC_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(32);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_DEPTH  = CSR_IDX_W'(2);

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_CLEAR = 2'd0,
      REQ_SPLAT = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NOP   = 2'd3
   } req_code_type;

   // one access to the grid memory
   typedef struct packed {
      logic               we;
      logic [GRID_AW-1:0] addr;
      logic [OCC_W-1:0]   wdata;
   } grid_req_type;

   // zero acts as one, anything past the maximum acts as the maximum
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                                input logic [DIM_W-1:0] m);
      logic [DIM_W-1:0] v;
      v = r;
      if (r == '0) begin
         v = DIM_W'(1);
      end else if (r > m) begin
         v = m;
      end
      return v;
   endfunction

endpackage

// File: rtl/tpsv_if.sv
// ----------------------------------------------------------------------------
// tpsv_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface tpsv_req_if;
   import tpsv_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [REQ_TYPE_W-1:0]   req_type;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic [VIDX_W-1:0]       voxel_index;

   modport source (output valid, req_type, pos_x, pos_y, pos_z, voxel_index,
                   input ready);
   modport sink   (input valid, req_type, pos_x, pos_y, pos_z, voxel_index,
                   output ready);
endinterface

interface tpsv_rsp_if;
   import tpsv_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [GRAD_W-1:0] grad_x;
   logic signed [GRAD_W-1:0] grad_y;
   logic signed [GRAD_W-1:0] grad_z;
   logic [CNT_W-1:0]         corners_written;
   logic [OCC_W-1:0]         voxel_value;

   modport source (output valid, grad_x, grad_y, grad_z, corners_written,
                   voxel_value, input ready);
   modport sink   (input valid, grad_x, grad_y, grad_z, corners_written,
                   voxel_value, output ready);
endinterface

// File: rtl/tpsv_grid.sv
// ----------------------------------------------------------------------------
// tpsv_grid
// Single-ported occupancy memory, read-first, registered read data.
// ----------------------------------------------------------------------------
module tpsv_grid (
   input  logic                   clock,
   input  tpsv_pkg::grid_req_type grid_req,
   output logic [tpsv_pkg::OCC_W-1:0] rd_data
);
   import tpsv_pkg::*;

   logic [OCC_W-1:0] mem [GRID_CELLS];
   logic [OCC_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (grid_req.we) begin
         mem[grid_req.addr] <= grid_req.wdata;
      end
      rd_data_ff <= mem[grid_req.addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/trilinear_point_splat_voxelizer_core.sv
// ----------------------------------------------------------------------------
// trilinear_point_splat_voxelizer_core
// Splats Q8.8 points into a 32x32x32 Q8.24 occupancy grid, clears, reads.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan takes one item at a time (valid/ready). req_type picks clear,
//    splat or read; type 3 is a no-op that returns zeros.
//  - rsp_chan returns exactly one item per request. The result sits in an
//    output register, so a new request is taken while it waits.
//  - csr_we/csr_index/csr_wdata set grid width, height, depth; write only
//    while idle. Out-of-range values are clamped to 1..32.
//  - Splat: the 8 corners are walked in order. An out-of-bounds corner is
//    skipped after its bounds check; an in-bounds corner uses the shared
//    multiplier and the grid's single port (6 multiplies, the first in the
//    bounds-check cycle, then read, write).
//  - Read: two multiplies for the grid size, and a memory read.
//  - Clear: one grid entry per cycle, over all 32768 entries.
//  - Reset runs the same clearing pass over all 32768 entries; req_chan.ready
//    stays low until it ends. Register writes are taken at any time.
//  - A stalled rsp_chan holds the finished result; the block then waits
//    before loading the next one.
// ----------------------------------------------------------------------------
module trilinear_point_splat_voxelizer_core (
   input  logic                            clock,
   input  logic                            reset,
   tpsv_req_if.sink                        req_chan,
   tpsv_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [tpsv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tpsv_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tpsv_pkg::*;

   // sequencer states, one-hot
   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_CLR    = 14'b00000000000010,
      S_CORNER = 14'b00000000000100,
      S_M2     = 14'b00000000001000,
      S_M3     = 14'b00000000010000,
      S_M4     = 14'b00000000100000,
      S_M5     = 14'b00000001000000,
      S_M6     = 14'b00000010000000,
      S_RD     = 14'b00000100000000,
      S_WR     = 14'b00001000000000,
      S_RV1    = 14'b00010000000000,
      S_RV2    = 14'b00100000000000,
      S_RV3    = 14'b01000000000000,
      S_DONE   = 14'b10000000000000
   } state_type;

   // control registers
   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               clr_rsp_ff, clr_rsp_in;      // clear came from a request
   logic [GRID_AW-1:0] clr_ff, clr_in;
   logic [2:0]         c_ff, c_in;                  // corner: {dx, dy, dz}
   logic [DIM_W-1:0]   gw_ff, gh_ff, gd_ff;         // raw register values

   // working registers
   logic [DIM_W-1:0]   w_ff, w_in, h_ff, h_in, d_ff, d_in;
   logic [7:0]         base_x_ff, base_x_in, base_y_ff, base_y_in;
   logic [7:0]         base_z_ff, base_z_in;
   logic [7:0]         fr_x_ff, fr_x_in, fr_y_ff, fr_y_in, fr_z_ff, fr_z_in;
   logic [VIDX_W-1:0]  vidx_ff, vidx_in;
   logic [16:0]        p_yz_ff, p_yz_in, p_xz_ff, p_xz_in, p_xy_ff, p_xy_in;
   logic [24:0]        wt_ff, wt_in;
   logic [10:0]        t_ff, t_in;
   logic [GRID_AW-1:0] addr_ff, addr_in;
   logic               rv_ok_ff, rv_ok_in;
   logic signed [18:0] gx_ff, gx_in, gy_ff, gy_in, gz_ff, gz_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [OCC_W-1:0]   val_ff, val_in;

   // output register
   logic signed [GRAD_W-1:0] o_gx_ff, o_gx_in, o_gy_ff, o_gy_in, o_gz_ff, o_gz_in;
   logic [CNT_W-1:0]         o_cnt_ff, o_cnt_in;
   logic [OCC_W-1:0]         o_val_ff, o_val_in;

   // shared multiplier
   logic [16:0] mul_a;
   logic [10:0] mul_b;
   logic [27:0] mul_p;

   // corner geometry
   logic       dx, dy, dz;
   logic [8:0] vx, vy, vz;
   logic [8:0] wx, wy, wz;
   logic       in_bounds;

   grid_req_type     grid_req;
   logic [OCC_W-1:0] rd_data;
   logic [OCC_W:0]   sum_wide;
   logic [OCC_W-1:0] sat_sum;
   logic             req_fire;
   logic             last_corner;

   assign req_fire    = req_chan.valid && req_chan.ready;
   assign last_corner = (c_ff == 3'd7);

   // Corner c picks near (0) or far (1) per axis.
   assign dx = c_ff[2];
   assign dy = c_ff[1];
   assign dz = c_ff[0];

   // base is floor(pos/256), sign-extended one bit so base+1 cannot wrap
   assign vx = {base_x_ff[7], base_x_ff} + {8'd0, dx};
   assign vy = {base_y_ff[7], base_y_ff} + {8'd0, dy};
   assign vz = {base_z_ff[7], base_z_ff} + {8'd0, dz};

   // far weight f, near weight 256-f
   assign wx = dx ? {1'b0, fr_x_ff} : (9'd256 - {1'b0, fr_x_ff});
   assign wy = dy ? {1'b0, fr_y_ff} : (9'd256 - {1'b0, fr_y_ff});
   assign wz = dz ? {1'b0, fr_z_ff} : (9'd256 - {1'b0, fr_z_ff});

   assign in_bounds = !vx[8] && (vx[7:0] < {2'b00, w_ff}) &&
                      !vy[8] && (vy[7:0] < {2'b00, h_ff}) &&
                      !vz[8] && (vz[7:0] < {2'b00, d_ff});

   // saturating accumulate
   assign sum_wide = {1'b0, rd_data} + (OCC_W + 1)'(wt_ff);
   assign sat_sum  = sum_wide[OCC_W] ? '1 : sum_wide[OCC_W-1:0];

   // operand select for the one multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_CORNER: begin
            mul_a = {8'd0, wy};
            mul_b = {2'd0, wz};
         end
         S_M2: begin
            mul_a = {8'd0, wx};
            mul_b = {2'd0, wz};
         end
         S_M3: begin
            mul_a = {8'd0, wx};
            mul_b = {2'd0, wy};
         end
         S_M4: begin
            mul_a = p_yz_ff;
            mul_b = {2'd0, wx};
         end
         S_M5: begin
            mul_a = {11'd0, h_ff};
            mul_b = {3'd0, vz[7:0]};
         end
         S_M6: begin
            mul_a = {11'd0, w_ff};
            mul_b = {3'd0, vy[7:0]} + t_ff;       // vy + h*vz
         end
         S_RV1: begin
            mul_a = {11'd0, h_ff};
            mul_b = {5'd0, d_ff};
         end
         S_RV2: begin
            mul_a = {11'd0, w_ff};
            mul_b = t_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = 28'(mul_a) * 28'(mul_b);

   // grid port
   always_comb begin
      grid_req.we    = 1'b0;
      grid_req.addr  = addr_ff;
      grid_req.wdata = sat_sum;
      unique case (state_ff)
         S_CLR: begin
            grid_req.we    = 1'b1;
            grid_req.addr  = clr_ff;
            grid_req.wdata = '0;
         end
         S_WR: begin
            grid_req.we = 1'b1;
         end
         S_RV2: begin
            grid_req.addr = GRID_AW'(vidx_ff);
         end
         default: begin
            grid_req.we = 1'b0;
         end
      endcase
   end

   tpsv_grid u_grid (
      .clock    (clock),
      .grid_req (grid_req),
      .rd_data  (rd_data)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      clr_rsp_in   = clr_rsp_ff;
      clr_in       = clr_ff;
      c_in         = c_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      d_in         = d_ff;
      base_x_in    = base_x_ff;
      base_y_in    = base_y_ff;
      base_z_in    = base_z_ff;
      fr_x_in      = fr_x_ff;
      fr_y_in      = fr_y_ff;
      fr_z_in      = fr_z_ff;
      vidx_in      = vidx_ff;
      p_yz_in      = p_yz_ff;
      p_xz_in      = p_xz_ff;
      p_xy_in      = p_xy_ff;
      wt_in        = wt_ff;
      t_in         = t_ff;
      addr_in      = addr_ff;
      rv_ok_in     = rv_ok_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      gz_in        = gz_ff;
      cnt_in       = cnt_ff;
      val_in       = val_ff;
      o_gx_in      = o_gx_ff;
      o_gy_in      = o_gy_ff;
      o_gz_in      = o_gz_ff;
      o_cnt_in     = o_cnt_ff;
      o_val_in     = o_val_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               w_in      = eff_dim(gw_ff, DIM_W'(MAX_X));
               h_in      = eff_dim(gh_ff, DIM_W'(MAX_Y));
               d_in      = eff_dim(gd_ff, DIM_W'(MAX_Z));
               base_x_in = req_chan.pos_x[15:8];
               base_y_in = req_chan.pos_y[15:8];
               base_z_in = req_chan.pos_z[15:8];
               fr_x_in   = req_chan.pos_x[7:0];
               fr_y_in   = req_chan.pos_y[7:0];
               fr_z_in   = req_chan.pos_z[7:0];
               vidx_in   = req_chan.voxel_index;
               gx_in     = '0;
               gy_in     = '0;
               gz_in     = '0;
               cnt_in    = '0;
               val_in    = '0;
               c_in      = '0;
               unique case (req_code_type'(req_chan.req_type))
                  REQ_CLEAR: begin
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLR;
                  end
                  REQ_SPLAT: state_in = S_CORNER;
                  REQ_READ:  state_in = S_RV1;
                  REQ_NOP:   state_in = S_DONE;
               endcase
            end
         end
         S_CLR: begin
            clr_in = clr_ff + GRID_AW'(1);
            if (clr_ff == GRID_AW'(GRID_CELLS - 1)) begin
               state_in = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_CORNER: begin
            if (in_bounds) begin
               p_yz_in  = mul_p[16:0];
               state_in = S_M2;
            end else if (last_corner) begin
               state_in = S_DONE;
            end else begin
               c_in = c_ff + 3'd1;
            end
         end
         S_M2: begin
            p_xz_in  = mul_p[16:0];
            state_in = S_M3;
         end
         S_M3: begin
            p_xy_in  = mul_p[16:0];
            state_in = S_M4;
         end
         S_M4: begin
            wt_in    = mul_p[24:0];
            state_in = S_M5;
         end
         S_M5: begin
            t_in     = mul_p[10:0];
            state_in = S_M6;
         end
         S_M6: begin
            // x + W*(y + H*z)
            addr_in  = GRID_AW'(mul_p + 28'(vx[7:0]));
            state_in = S_RD;
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            gx_in  = dx ? gx_ff + 19'(p_yz_ff) : gx_ff - 19'(p_yz_ff);
            gy_in  = dy ? gy_ff + 19'(p_xz_ff) : gy_ff - 19'(p_xz_ff);
            gz_in  = dz ? gz_ff + 19'(p_xy_ff) : gz_ff - 19'(p_xy_ff);
            cnt_in = cnt_ff + CNT_W'(1);
            if (last_corner) begin
               state_in = S_DONE;
            end else begin
               c_in     = c_ff + 3'd1;
               state_in = S_CORNER;
            end
         end
         S_RV1: begin
            t_in     = mul_p[10:0];                   // H*D
            state_in = S_RV2;
         end
         S_RV2: begin
            // memory read is issued this cycle at the requested index
            rv_ok_in = (28'(vidx_ff) < mul_p) && (32'(vidx_ff) < 32'(GRID_CELLS));
            state_in = S_RV3;
         end
         S_RV3: begin
            val_in   = rv_ok_ff ? rd_data : '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               o_gx_in      = gx_ff[GRAD_W-1:0];
               o_gy_in      = gy_ff[GRAD_W-1:0];
               o_gz_in      = gz_ff[GRAD_W-1:0];
               o_cnt_in     = cnt_ff;
               o_val_in     = val_ff;
               rsp_valid_in = 1'b1;
               clr_rsp_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;        // power-up clearing pass
         rsp_valid_ff <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         clr_ff       <= '0;
         c_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_rsp_ff   <= clr_rsp_in;
         clr_ff       <= clr_in;
         c_ff         <= c_in;
      end
   end

   // dimension registers; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff <= DIM_RESET;
         gh_ff <= DIM_RESET;
         gd_ff <= DIM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  gw_ff <= csr_wdata;
            CSR_GRID_HEIGHT: gh_ff <= csr_wdata;
            CSR_GRID_DEPTH:  gd_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      w_ff      <= w_in;
      h_ff      <= h_in;
      d_ff      <= d_in;
      base_x_ff <= base_x_in;
      base_y_ff <= base_y_in;
      base_z_ff <= base_z_in;
      fr_x_ff   <= fr_x_in;
      fr_y_ff   <= fr_y_in;
      fr_z_ff   <= fr_z_in;
      vidx_ff   <= vidx_in;
      p_yz_ff   <= p_yz_in;
      p_xz_ff   <= p_xz_in;
      p_xy_ff   <= p_xy_in;
      wt_ff     <= wt_in;
      t_ff      <= t_in;
      addr_ff   <= addr_in;
      rv_ok_ff  <= rv_ok_in;
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
      gz_ff     <= gz_in;
      cnt_ff    <= cnt_in;
      val_ff    <= val_in;
      o_gx_ff   <= o_gx_in;
      o_gy_ff   <= o_gy_in;
      o_gz_ff   <= o_gz_in;
      o_cnt_ff  <= o_cnt_in;
      o_val_ff  <= o_val_in;
   end

   assign req_chan.ready           = (state_ff == S_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.grad_x          = o_gx_ff;
   assign rsp_chan.grad_y          = o_gy_ff;
   assign rsp_chan.grad_z          = o_gz_ff;
   assign rsp_chan.corners_written = o_cnt_ff;
   assign rsp_chan.voxel_value     = o_val_ff;

   // checks
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (state_ff == S_CLR))
      else $error("reset did not start the clearing pass");

   a_splat_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_chan.req_type == REQ_SPLAT)) |=> (state_ff == S_CORNER))
      else $error("splat item did not enter the corner walk");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      grid_req.we |-> ((state_ff == S_WR) || (state_ff == S_CLR)))
      else $error("grid written outside clear or corner update");

   a_sat_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |-> (grid_req.wdata >= rd_data))
      else $error("occupancy update decreased a voxel");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trilinear point splat voxelizer core. A shadow
// occupancy grid predicts every result item at request accept; each returned
// item is compared field by field against the oldest prediction. Directed
// points, dimension corner cases, occupancy saturation, back-pressure and
// randomized mixes run back to back, mostly with random idle gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tpsv_pkg::*;

   // unused register slot; the block must ignore writes to it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);

   // Cycles with no accept on either channel before the run is called hung.
   // A clear (and the reset clearing pass) keeps both channels quiet while it
   // writes all 32768 grid entries, so the limit sits well above that count.
   localparam int QUIET_LIMIT = 150000;

   // expected content of one result item
   typedef struct {
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
      logic signed [GRAD_W-1:0] grad_z;
      logic [CNT_W-1:0]         corners;
      logic [OCC_W-1:0]         occ;
   } voxel_rsp_t;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tpsv_req_if req_bus ();
   tpsv_rsp_if rsp_bus ();

   trilinear_point_splat_voxelizer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow state of the block
   logic [OCC_W-1:0] occ_shadow [GRID_CELLS];
   logic [DIM_W-1:0] dim_reg [3];
   voxel_rsp_t       pending_rsp [$];

   int  err_cnt      = 0;
   int  clears_left  = 2;   // clears allowed in the random mix (each one a full grid pass)
   int  rsp_hold_len = 0;   // nonzero: receiver holds ready low for a stretch of this length
   bit  req_calm     = 1'b0; // sender: no idle gaps
   bit  rsp_calm     = 1'b0; // receiver: no idle gaps

   // ------------------------------------------------------------------------
   // clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // register value to extent in use: 0 acts as 1, past the max acts as max
   function automatic int extent(logic [DIM_W-1:0] r, int lim);
      if (r == '0) return 1;
      if (int'(r) > lim) return lim;
      return int'(r);
   endfunction

   // Works out the result of one request and updates the shadow grid.
   function automatic voxel_rsp_t voxel_predict(req_code_type kind,
                                                logic signed [POS_W-1:0] px,
                                                logic signed [POS_W-1:0] py,
                                                logic signed [POS_W-1:0] pz,
                                                logic [VIDX_W-1:0] vidx);
      voxel_rsp_t  r;
      int          pos [3];
      int          base [3];
      int          wgt [3][2];
      int          gs [3];
      int          ext_w, ext_h, ext_d;
      int          vx, vy, vz, dx, dy, dz, cnt;
      int unsigned wt, idx;
      logic [OCC_W:0] acc;

      r     = '{default: '0};
      ext_w = extent(dim_reg[0], MAX_X);
      ext_h = extent(dim_reg[1], MAX_Y);
      ext_d = extent(dim_reg[2], MAX_Z);
      case (kind)
         REQ_CLEAR: begin
            foreach (occ_shadow[i]) occ_shadow[i] = '0;
         end
         REQ_SPLAT: begin
            pos[0] = int'(px);
            pos[1] = int'(py);
            pos[2] = int'(pz);
            for (int a = 0; a < 3; a++) begin
               // floor of the Q8.8 value, fraction in Q0.8
               base[a]   = pos[a] >>> 8;
               wgt[a][1] = pos[a] & 255;
               wgt[a][0] = 256 - wgt[a][1];
               gs[a]     = 0;
            end
            cnt = 0;
            for (int c = 0; c < 8; c++) begin
               dx = (c >> 2) & 1;
               dy = (c >> 1) & 1;
               dz = c & 1;
               vx = base[0] + dx;
               vy = base[1] + dy;
               vz = base[2] + dz;
               // corners outside the grid in use are skipped entirely
               if (vx < 0 || vx >= ext_w || vy < 0 || vy >= ext_h ||
                   vz < 0 || vz >= ext_d) continue;
               wt  = wgt[0][dx] * wgt[1][dy] * wgt[2][dz];
               idx = vx + vy * ext_w + vz * ext_w * ext_h;
               acc = {1'b0, occ_shadow[idx]} + (OCC_W + 1)'(wt);
               occ_shadow[idx] = acc[OCC_W] ? '1 : acc[OCC_W-1:0];
               gs[0] += dx ? wgt[1][dy] * wgt[2][dz] : -(wgt[1][dy] * wgt[2][dz]);
               gs[1] += dy ? wgt[0][dx] * wgt[2][dz] : -(wgt[0][dx] * wgt[2][dz]);
               gs[2] += dz ? wgt[0][dx] * wgt[1][dy] : -(wgt[0][dx] * wgt[1][dy]);
               cnt++;
            end
            r.grad_x  = GRAD_W'(gs[0]);
            r.grad_y  = GRAD_W'(gs[1]);
            r.grad_z  = GRAD_W'(gs[2]);
            r.corners = CNT_W'(cnt);
         end
         REQ_READ: begin
            if (int'(vidx) < ext_w * ext_h * ext_d) r.occ = occ_shadow[vidx];
         end
         default: ;  // no-op request: all-zero result
      endcase
      return r;
   endfunction

   // Request side: register writes and accepted items feed the shadow model.
   always @(posedge clock) begin
      if (reset) begin
         foreach (occ_shadow[i]) occ_shadow[i] = '0;
         foreach (dim_reg[i]) dim_reg[i] = DIM_RESET;
      end else begin
         if (csr_we === 1'b1) begin
            case (csr_index)
               CSR_GRID_WIDTH:  dim_reg[0] = csr_wdata;
               CSR_GRID_HEIGHT: dim_reg[1] = csr_wdata;
               CSR_GRID_DEPTH:  dim_reg[2] = csr_wdata;
               default: ;
            endcase
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            pending_rsp.push_back(voxel_predict(req_code_type'(req_bus.req_type),
                                                req_bus.pos_x, req_bus.pos_y,
                                                req_bus.pos_z, req_bus.voxel_index));
         end
      end
   end

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   task automatic check_field(string name, logic signed [OCC_W:0] want,
                              logic signed [OCC_W:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_cnt++;
      end
   endtask

   always @(posedge clock) begin
      voxel_rsp_t want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $error("result item with no request outstanding");
            err_cnt++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("grad_x", want.grad_x, rsp_bus.grad_x);
            check_field("grad_y", want.grad_y, rsp_bus.grad_y);
            check_field("grad_z", want.grad_z, rsp_bus.grad_z);
            check_field("corners_written", want.corners, rsp_bus.corners_written);
            check_field("voxel_value", want.occ, rsp_bus.voxel_value);
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: no accept on either channel for too long ends the run
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL trilinear_point_splat_voxelizer_core");
      $finish;
   end

   // ------------------------------------------------------------------------
   // idle gaps: mostly none or short, now and then a long one
   // ------------------------------------------------------------------------
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: random ready pattern, plus a long hold-off on request.
   initial begin : rsp_sink
      int n;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            n = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_bus.ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            n = rsp_calm ? 0 : draw_gap();
            if (n == 0) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               repeat (n - 1) @(negedge clock);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // Offers one request item and returns once it is accepted.
   task automatic send_req(req_code_type kind, logic signed [POS_W-1:0] px,
                           logic signed [POS_W-1:0] py,
                           logic signed [POS_W-1:0] pz,
                           logic [VIDX_W-1:0] vidx);
      int gap;
      gap = req_calm ? 0 : draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= kind;
      req_bus.pos_x       <= px;
      req_bus.pos_y       <= py;
      req_bus.pos_z       <= pz;
      req_bus.voxel_index <= vidx;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Sender pauses until every outstanding result item is back.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                           logic [DIM_W-1:0] d);
      wait_idle();
      csr_write(CSR_GRID_WIDTH, w);
      csr_write(CSR_GRID_HEIGHT, h);
      csr_write(CSR_GRID_DEPTH, d);
   endtask

   // Coordinate around the grid in use, a voxel or two either side; some
   // exact integers or fraction extremes, some fully random.
   function automatic logic signed [POS_W-1:0] pos_near(int ext);
      int v;
      int pick;
      pick = $urandom_range(0, 99);
      v = $urandom_range(0, (ext + 4) * 256 - 1) - 2 * 256;
      if (pick < 10) begin
         v = $urandom_range(0, 65535);
      end else if (pick < 30) begin
         case ($urandom_range(0, 2))
            0:       v = v & ~255;
            1:       v = v | 255;
            default: v = (v & ~255) | 1;
         endcase
      end
      return POS_W'(v);
   endfunction

   // Read index: mostly inside the grid in use, sometimes anywhere.
   function automatic logic [VIDX_W-1:0] pick_index();
      int cells;
      cells = extent(dim_reg[0], MAX_X) * extent(dim_reg[1], MAX_Y) *
              extent(dim_reg[2], MAX_Z);
      if ($urandom_range(0, 3) != 0) return VIDX_W'($urandom_range(0, cells - 1));
      return VIDX_W'($urandom);
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // Hand-picked points at reset dimensions: interior, edges, far outside,
   // coordinate extremes, reads, no-op and a clear.
   task automatic test_directed_points();
      send_req(REQ_SPLAT, 16'sh0000, 16'sh0000, 16'sh0000, '0);   // all 8 corners
      send_req(REQ_SPLAT, 16'sh1F80, 16'sh1F80, 16'sh1F80, '0);   // top corner only
      send_req(REQ_SPLAT, -16'sd128, -16'sd128, -16'sd128, '0);   // bottom corner only
      send_req(REQ_SPLAT, -16'sd1, -16'sd1, -16'sd1, '1);         // fraction 0xFF, base -1
      send_req(REQ_SPLAT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, '0);   // far past the grid
      send_req(REQ_SPLAT, 16'sh8000, 16'sh8000, 16'sh8000, '1);   // far below the grid
      send_req(REQ_SPLAT, 16'sh8000, 16'sh7FFF, 16'sh0000, '0);
      send_req(REQ_SPLAT, 16'sh00FF, 16'sh0101, 16'sh1F80, '0);
      send_req(REQ_SPLAT, 16'sh1001, 16'sh08FF, 16'sh00FF, '0);
      send_req(REQ_SPLAT, 16'sh0F80, 16'sh1E40, 16'sh0001, '0);
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(0));
      send_req(REQ_READ, '1, '1, '1, VIDX_W'(1057));
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(32767));
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(16 + 8 * 32));
      send_req(REQ_NOP, 16'sh7FFF, 16'sh8000, -16'sd1, '1);
      send_req(REQ_CLEAR, 16'sh1234, 16'sh4321, 16'sh0F0F, VIDX_W'(0));
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(0));
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(32767));
   endtask

   // Dimension registers at and past their limits, the spare register slot,
   // and stored values readdressed after a dimension change.
   task automatic test_dim_limits();
      set_dims(6'd0, 6'd0, 6'd0);   // acts as 1x1x1
      send_req(REQ_SPLAT, 16'sh0080, 16'sh0080, 16'sh0080, '0);
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(0));
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(1));   // beyond the grid in use
      set_dims(6'd63, 6'd63, 6'd63); // acts as 32x32x32
      send_req(REQ_SPLAT, 16'sh0540, 16'sh0200, 16'sh0300, '0);
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(0));
      set_dims(6'd4, 6'd32, 6'd32);
      csr_write(CSR_SPARE, 6'd1);    // must change nothing
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(5 + 2 * 32 + 3 * 1024));
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(5 + 2 * 4 + 3 * 128));
      send_req(REQ_SPLAT, 16'sh0364, 16'sh0000, 16'sh0000, '0); // x far corner clipped
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(4095));
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(4096));
   endtask

   // Piles splats onto one voxel of a 1x1x1 grid until the occupancy pins at
   // its maximum, reading it back along the way, then clears.
   task automatic test_saturation();
      set_dims(6'd1, 6'd1, 6'd1);
      for (int i = 0; i < 320; i++) begin
         if (i % 16 == 15)
            send_req(REQ_READ, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                     VIDX_W'(0));
         else if ($urandom_range(0, 9) < 8)
            send_req(REQ_SPLAT, '0, '0, '0, VIDX_W'($urandom));
         else
            send_req(REQ_SPLAT, POS_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 3)),
                     POS_W'($urandom_range(0, 3)), VIDX_W'($urandom));
      end
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(0));
      send_req(REQ_CLEAR, '0, '0, '0, '0);
      send_req(REQ_READ, '0, '0, '0, VIDX_W'(0));
   endtask

   // Random request mix at the current dimensions.
   task automatic run_mixed(int n);
      int r;
      int ew, eh, ed;
      ew = extent(dim_reg[0], MAX_X);
      eh = extent(dim_reg[1], MAX_Y);
      ed = extent(dim_reg[2], MAX_Z);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 999);
         if (r < 4 && clears_left > 0) begin
            clears_left--;
            send_req(REQ_CLEAR, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                     VIDX_W'($urandom));
         end else if (r < 40) begin
            send_req(REQ_NOP, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                     VIDX_W'($urandom));
         end else if (r < 320) begin
            send_req(REQ_READ, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                     pick_index());
         end else if (r < 380) begin
            send_req(REQ_SPLAT, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                     VIDX_W'($urandom));
         end else begin
            send_req(REQ_SPLAT, pos_near(ew), pos_near(eh), pos_near(ed),
                     VIDX_W'($urandom));
         end
      end
   endtask

   task automatic test_random_phase(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                    logic [DIM_W-1:0] d, int n);
      set_dims(w, h, d);
      run_mixed(n);
   endtask

   // Receiver stalls for a long stretch while the sender keeps offering, so
   // the held result backs the block up; then the sender drains.
   task automatic test_backpressure();
      set_dims(6'd8, 6'd6, 6'd5);
      req_calm     = 1'b1;
      rsp_hold_len = 400;
      run_mixed(30);
      req_calm     = 1'b0;
      wait_idle();
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_streaming();
      req_calm = 1'b1;
      rsp_calm = 1'b1;
      test_random_phase(6'd2, 6'd3, 6'd4, 90);
      wait_idle();
      req_calm = 1'b0;
      rsp_calm = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = REQ_NOP;
      req_bus.pos_x       = '0;
      req_bus.pos_y       = '0;
      req_bus.pos_z       = '0;
      req_bus.voxel_index = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset runs a full clearing pass; send_req waits on ready for it
      test_directed_points();
      test_dim_limits();
      test_saturation();
      test_random_phase(6'd1, 6'd1, 6'd1, 60);
      test_random_phase(6'd32, 6'd32, 6'd32, 90);
      test_random_phase(6'd0, 6'd63, 6'd5, 90);
      test_random_phase(6'd63, 6'd0, 6'd32, 90);
      test_backpressure();
      test_streaming();
      test_random_phase(DIM_W'($urandom_range(1, 32)), DIM_W'($urandom_range(1, 32)),
                        DIM_W'($urandom_range(1, 32)), 80);
      test_random_phase(DIM_W'($urandom_range(0, 63)), DIM_W'($urandom_range(0, 63)),
                        DIM_W'($urandom_range(0, 63)), 80);

      // drain, then leave room for a slow splat to show a stray result
      wait_idle();
      repeat (100) @(posedge clock);
      if (err_cnt == 0 && pending_rsp.size() == 0) begin
         $display("PASS trilinear_point_splat_voxelizer_core");
      end else begin
         $display("FAIL trilinear_point_splat_voxelizer_core");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/tpsv_pkg.sv
rtl/tpsv_if.sv
rtl/tpsv_grid.sv
rtl/trilinear_point_splat_voxelizer_core.sv
dv/tb_top.sv
